>>> rtl/lrw_pkg.sv
package lrw_pkg;

  localparam int unsigned GRID_SIZE   = 64;
  localparam int unsigned COORD_W     = $clog2(GRID_SIZE);
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned WEIGHT_W    = WEIGHT_BITS + 1;
  localparam int unsigned EDGE_LIMIT  = 64;
  localparam int unsigned EDGE_W      = 6;
  localparam int unsigned VCOUNT_W    = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(4);

  // bresenham error, signed, with headroom over the spans
  localparam int unsigned ERR_W = COORD_W + 3;

  // serial divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = WEIGHT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic load;
    logic step;
  } lrw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero_len;
    logic last;
  } lrw_sts_t;

endpackage

>>> rtl/lrw_in_if.sv
interface lrw_in_if import lrw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   start_x;
  logic [COORD_W-1:0]   start_y;
  logic [COORD_W-1:0]   end_x;
  logic [COORD_W-1:0]   end_y;
  logic [EDGE_W-1:0]    edge_number;

  modport source (
    output valid, start_x, start_y, end_x, end_y, edge_number,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y, edge_number,
    output ready
  );
endinterface

>>> rtl/lrw_out_if.sv
interface lrw_out_if import lrw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   point_x;
  logic [COORD_W-1:0]   point_y;
  logic [EDGE_W-1:0]    own_edge;
  logic [EDGE_W-1:0]    neighbor_edge;
  logic [WEIGHT_W-1:0]  neighbor_weight;
  logic                 last_point;

  modport source (
    output valid, point_x, point_y, own_edge, neighbor_edge, neighbor_weight,
           last_point,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, own_edge, neighbor_edge, neighbor_weight,
           last_point,
    output ready
  );
endinterface

>>> rtl/lrw_div.sv
module lrw_div import lrw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [COORD_W-1:0]  divisor_i,
  output logic [WEIGHT_W-1:0] quot_o,
  output logic [COORD_W-1:0]  rem_o,
  output logic                done_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WEIGHT_W-1:0]  quot_q, quot_d;
  logic [COORD_W-1:0]   rem_q, rem_d;
  logic [COORD_W-1:0]   div_q;
  logic [COORD_W:0]     trial;
  logic                 ge;

  assign done_o = (cnt_q == DIV_CNT_W'(DIV_STEPS));
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  // restoring division of one (2^weight_bits) by the major span
  assign trial = {rem_q, quot_q[WEIGHT_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = '0;
      quot_d = WEIGHT_W'(1) << WEIGHT_BITS;
      rem_d  = '0;
    end else if (!done_o) begin
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      quot_d = {quot_q[WEIGHT_W-2:0], ge};
      rem_d  = ge ? COORD_W'(trial - {1'b0, div_q}) : trial[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= DIV_CNT_W'(DIV_STEPS);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

endmodule

>>> rtl/lrw_dp.sv
module lrw_dp import lrw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrw_cmd_t             cmd_i,
  output lrw_sts_t             sts_o,
  input  logic                 cfg_we_i,
  input  logic [VCOUNT_W-1:0]  cfg_wdata_i,
  input  logic [COORD_W-1:0]   start_x_i,
  input  logic [COORD_W-1:0]   start_y_i,
  input  logic [COORD_W-1:0]   end_x_i,
  input  logic [COORD_W-1:0]   end_y_i,
  input  logic [EDGE_W-1:0]    edge_number_i,
  output logic [COORD_W-1:0]   point_x_o,
  output logic [COORD_W-1:0]   point_y_o,
  output logic [EDGE_W-1:0]    own_edge_o,
  output logic [EDGE_W-1:0]    neighbor_edge_o,
  output logic [WEIGHT_W-1:0]  neighbor_weight_o,
  output logic                 last_point_o
);

  logic [VCOUNT_W-1:0] vcount_q;

  logic [COORD_W-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_W-1:0]  span_x_q, span_y_q, n_q, cnt_q, cnt_d;
  logic                dir_x_q, dir_y_q;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [EDGE_W-1:0]   own_q, nb_q;
  logic [WEIGHT_W-1:0] wacc_q, wacc_d;
  logic [COORD_W-1:0]  wrem_q, wrem_d;

  logic [COORD_W-1:0]  in_dx, in_dy, in_n;
  logic                in_x_major;
  logic [VCOUNT_W-1:0] count_in_use, edge_next;
  logic signed [ERR_W-1:0] err_init;

  logic signed [ERR_W-1:0] dx_s, dy_s;
  logic                move_x, move_y;
  logic [COORD_W:0]    rem_sum;
  logic                carry;

  logic [WEIGHT_W-1:0] div_quot;
  logic [COORD_W-1:0]  div_rem;
  logic                div_done;

  lrw_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.load),
    .divisor_i (in_n),
    .quot_o    (div_quot),
    .rem_o     (div_rem),
    .done_o    (div_done)
  );

  // edge setup from the incoming item
  assign in_dx      = (end_x_i > start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign in_dy      = (end_y_i > start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
  assign in_x_major = (in_dx > in_dy);
  assign in_n       = in_x_major ? in_dx : in_dy;
  assign err_init   = in_x_major ? ERR_W'({1'b0, in_dx[COORD_W-1:1]})
                                 : -ERR_W'({1'b0, in_dy[COORD_W-1:1]});

  assign count_in_use = (vcount_q > VCOUNT_W'(EDGE_LIMIT)) ? VCOUNT_W'(EDGE_LIMIT) : vcount_q;
  assign edge_next    = VCOUNT_W'(edge_number_i) + VCOUNT_W'(1);

  // one bresenham step
  assign dx_s   = ERR_W'(span_x_q);
  assign dy_s   = ERR_W'(span_y_q);
  assign move_x = (err_q > -dx_s);
  assign move_y = (err_q < dy_s);

  // weight accumulates quotient plus the carried remainder
  assign rem_sum = {1'b0, wrem_q} + {1'b0, div_rem};
  assign carry   = (rem_sum >= {1'b0, n_q});

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    err_d   = err_q;
    if (move_x) begin
      err_d   = err_d - dy_s;
      cur_x_d = dir_x_q ? cur_x_q + COORD_W'(1) : cur_x_q - COORD_W'(1);
    end
    if (move_y) begin
      err_d   = err_d + dx_s;
      cur_y_d = dir_y_q ? cur_y_q + COORD_W'(1) : cur_y_q - COORD_W'(1);
    end
    cnt_d  = cnt_q + COORD_W'(1);
    wacc_d = wacc_q + div_quot + WEIGHT_W'(carry);
    wrem_d = carry ? COORD_W'(rem_sum - {1'b0, n_q}) : rem_sum[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q  <= start_x_i;
      cur_y_q  <= start_y_i;
      span_x_q <= in_dx;
      span_y_q <= in_dy;
      n_q      <= in_n;
      dir_x_q  <= (start_x_i < end_x_i);
      dir_y_q  <= (start_y_i < end_y_i);
      err_q    <= err_init;
      own_q    <= edge_number_i;
      nb_q     <= (edge_next < count_in_use) ? edge_next[EDGE_W-1:0] : '0;
      cnt_q    <= '0;
      wacc_q   <= '0;
      wrem_q   <= '0;
    end else if (cmd_i.step) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      wacc_q  <= wacc_d;
      wrem_q  <= wrem_d;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.zero_len = (n_q == '0);
  assign sts_o.last     = (cnt_q == n_q);

  assign point_x_o         = cur_x_q;
  assign point_y_o         = cur_y_q;
  assign own_edge_o        = own_q;
  assign neighbor_edge_o   = nb_q;
  assign neighbor_weight_o = wacc_q;
  assign last_point_o      = (cnt_q == n_q);

endmodule

>>> rtl/lrw_ctrl.sv
module lrw_ctrl import lrw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lrw_cmd_t cmd_o,
  input  lrw_sts_t sts_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_fire, out_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign cmd_o.load = in_fire;
  assign cmd_o.step = out_fire && !sts_i.last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) state_d = StDiv;
      end
      StDiv: begin
        // zero-length edge has no steps, so skip the weight division
        if (sts_i.zero_len || sts_i.div_done) state_d = StEmit;
      end
      StEmit: begin
        if (out_fire && sts_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/line_raster_with_weights.sv
// channel   dir  handshake      content
// edge_i    in   valid/ready    start_x, start_y, end_x, end_y, edge_number
// point_o   out  valid/ready    point_x, point_y, own_edge, neighbor_edge,
//                               neighbor_weight, last_point
// cfg       in   cfg_we_i       vertex_count, 7 bits, reset value 4
//
// one edge item at a time: accept, then a serial divider forms the weight
// step, then one point per cycle while point_o is ready, n+1 points for
// major span n; a zero-length edge skips the divider wait and gives one point
// reset returns the controller to idle and vertex_count to 4
// a stalled point_o holds the current point; edge_i.ready stays low until done
module line_raster_with_weights import lrw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [VCOUNT_W-1:0] cfg_wdata_i,
  lrw_in_if.sink              edge_i,
  lrw_out_if.source           point_o
);

  lrw_cmd_t cmd;
  lrw_sts_t sts;

  lrw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (edge_i.valid),
    .in_ready_o  (edge_i.ready),
    .out_valid_o (point_o.valid),
    .out_ready_i (point_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lrw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_x_i         (edge_i.start_x),
    .start_y_i         (edge_i.start_y),
    .end_x_i           (edge_i.end_x),
    .end_y_i           (edge_i.end_y),
    .edge_number_i     (edge_i.edge_number),
    .point_x_o         (point_o.point_x),
    .point_y_o         (point_o.point_y),
    .own_edge_o        (point_o.own_edge),
    .neighbor_edge_o   (point_o.neighbor_edge),
    .neighbor_weight_o (point_o.neighbor_weight),
    .last_point_o      (point_o.last_point)
  );

endmodule

>>> verif/line_raster_with_weights_tb.sv
module line_raster_with_weights_tb;
  import lrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 20;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [EDGE_W-1:0]  edge_number;
  } edge_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [EDGE_W-1:0]   own;
    logic [EDGE_W-1:0]   nb;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } point_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [VCOUNT_W-1:0] cfg_wdata_i;

  lrw_in_if  edge_if ();
  lrw_out_if point_if ();

  line_raster_with_weights u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_if),
    .point_o     (point_if)
  );

  point_t              expected_points[$];
  logic [VCOUNT_W-1:0] vertex_count_now = VCOUNT_RESET;
  int                  fail_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add_expected(point_t p);
    expected_points.insert(expected_points.size(), p);
  endfunction

  // bresenham walk plus the Q1.16 neighbor weight of every point
  function automatic void predict_points(edge_item_t e);
    int     x0, y0, x1, y1, dx, dy, sx, sy, err, e2, n, cnt;
    point_t p;
    x0 = e.start_x;
    y0 = e.start_y;
    x1 = e.end_x;
    y1 = e.end_y;
    cnt = (vertex_count_now > EDGE_LIMIT) ? EDGE_LIMIT : vertex_count_now;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    n = (dx > dy) ? dx : dy;
    p.own = e.edge_number;
    p.nb = (int'(e.edge_number) + 1 < cnt) ? e.edge_number + 1'b1 : '0;
    p.x = x0[COORD_W-1:0];
    p.y = y0[COORD_W-1:0];
    p.weight = '0;
    p.last = (n == 0);
    add_expected(p);
    for (int j = 0; j < n; j++) begin
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x0 += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y0 += sy;
      end
      p.x = x0[COORD_W-1:0];
      p.y = y0[COORD_W-1:0];
      p.weight = WEIGHT_W'(((j + 1) << WEIGHT_BITS) / n);
      p.last = (j + 1 == n);
      add_expected(p);
    end
  endfunction

  function automatic edge_item_t make_edge(int sx, int sy, int ex, int ey, int en);
    edge_item_t e;
    e.start_x = sx[COORD_W-1:0];
    e.start_y = sy[COORD_W-1:0];
    e.end_x = ex[COORD_W-1:0];
    e.end_y = ey[COORD_W-1:0];
    e.edge_number = en[EDGE_W-1:0];
    return e;
  endfunction

  function automatic int near_coord(int c);
    int v;
    v = c + int'($urandom_range(12)) - 6;
    if (v < 0) v = 0;
    if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
    return v;
  endfunction

  // mostly short edges with an index inside the cage, some anywhere
  function automatic edge_item_t random_edge();
    int sx, sy, ex, ey, en, cnt;
    sx = $urandom_range(GRID_SIZE - 1);
    sy = $urandom_range(GRID_SIZE - 1);
    if ($urandom_range(99) < 65) begin
      ex = near_coord(sx);
      ey = near_coord(sy);
    end else begin
      ex = $urandom_range(GRID_SIZE - 1);
      ey = $urandom_range(GRID_SIZE - 1);
    end
    cnt = (vertex_count_now > EDGE_LIMIT) ? EDGE_LIMIT : vertex_count_now;
    if (cnt != 0 && $urandom_range(3) != 0) en = $urandom_range(cnt - 1);
    else en = $urandom_range(63);
    return make_edge(sx, sy, ex, ey, en);
  endfunction

  task automatic send_edge(edge_item_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      edge_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    edge_if.valid       <= 1'b1;
    edge_if.start_x     <= e.start_x;
    edge_if.start_y     <= e.start_y;
    edge_if.end_x       <= e.end_x;
    edge_if.end_y       <= e.end_y;
    edge_if.edge_number <= e.edge_number;
    @(posedge clk_i);
    while (!edge_if.ready) @(posedge clk_i);
    predict_points(e);
  endtask

  task automatic wait_points_drained();
    edge_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(logic [VCOUNT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vertex_count_now = v;
  endtask

  task automatic test_directed_edges();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // zero-length edges at both corners
    send_edge(make_edge(0, 0, 0, 0, 0));
    send_edge(make_edge(63, 63, 63, 63, 3));
    send_edge(make_edge(0, 0, 63, 0, 1));
    send_edge(make_edge(63, 5, 0, 5, 2));
    send_edge(make_edge(10, 0, 10, 63, 0));
    send_edge(make_edge(20, 63, 20, 0, 3));
    send_edge(make_edge(0, 0, 63, 63, 1));
    send_edge(make_edge(63, 0, 0, 63, 2));
    send_edge(make_edge(5, 5, 12, 9, 0));
    send_edge(make_edge(12, 9, 5, 5, 1));
    send_edge(make_edge(3, 3, 6, 20, 2));
    send_edge(make_edge(30, 40, 27, 1, 3));
    // edge index at or above the vertex count
    send_edge(make_edge(0, 63, 63, 62, 63));
    send_edge(make_edge(1, 1, 4, 4, 5));
    send_edge(make_edge(7, 7, 8, 8, 0));
    send_edge(make_edge(7, 7, 9, 8, 0));
    send_edge(make_edge(7, 7, 8, 10, 1));
    send_edge(make_edge(42, 21, 21, 42, 2));
    send_edge(make_edge(0, 0, 1, 0, 0));
    wait_points_drained();
  endtask

  task automatic test_vertex_wrap();
    int counts[6] = '{0, 1, 64, 127, 65, 37};
    edge_item_t e;
    send_idle_pct = 20;
    recv_stall_pct = 20;
    foreach (counts[i]) begin
      set_vertex_count(counts[i][VCOUNT_W-1:0]);
      for (int k = 0; k < 4; k++) begin
        e = random_edge();
        case (k)
          0: e.edge_number = '0;
          1: e.edge_number = '1;
          2: e.edge_number = EDGE_W'(counts[i] - 1);
          default: e.edge_number = EDGE_W'(counts[i]);
        endcase
        send_edge(e);
      end
      wait_points_drained();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_vertex_count(VCOUNT_RESET);
    hold_requests++;
    send_edge(make_edge(0, 0, 63, 20, 2));
    for (int k = 0; k < 4; k++) send_edge(random_edge());
    // sender stops until the last point is out
    wait_points_drained();
    send_edge(make_edge(63, 63, 0, 0, 3));
    send_edge(random_edge());
    wait_points_drained();
  endtask

  task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
    logic [VCOUNT_W-1:0] v;
    v = ($urandom_range(9) == 0) ? VCOUNT_W'($urandom_range(127, 65))
                                 : VCOUNT_W'($urandom_range(64, 1));
    set_vertex_count(v);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < items; k++) send_edge(random_edge());
    wait_points_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    edge_if.valid = 1'b0;
    edge_if.start_x = '0;
    edge_if.start_y = '0;
    edge_if.end_x = '0;
    edge_if.end_y = '0;
    edge_if.edge_number = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_vertex_wrap();
    test_output_backpressure();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 66, 0);
    test_random_traffic(30, 0, 66);
    test_random_traffic(30, 31, 31);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // point receiver, with a long hold-off on request
  initial begin
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    point_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        point_if.ready <= 1'b0;
      end else begin
        point_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && point_if.valid && point_if.ready) begin
      if (expected_points.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t unexpected point: expected none, got x=%0d y=%0d w=%0d",
                   $time, point_if.point_x, point_if.point_y, point_if.neighbor_weight);
      end else begin
        want = expected_points.pop_front();
        check_field("point_x", want.x, point_if.point_x);
        check_field("point_y", want.y, point_if.point_y);
        check_field("own_edge", want.own, point_if.own_edge);
        check_field("neighbor_edge", want.nb, point_if.neighbor_edge);
        check_field("neighbor_weight", want.weight, point_if.neighbor_weight);
        check_field("last_point", want.last, point_if.last_point);
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((edge_if.valid && edge_if.ready) || (point_if.valid && point_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
